FILE: rtl/rewb_pkg.sv
// Shared types, constants and helper functions of the routing entry edit write buffer.
`timescale 1ns / 1ps
`default_nettype none
package rewb_pkg;

	localparam int CONTROLLERS    = 128;
	localparam int CHANNELS       = 16;
	localparam int BUFFER_ENTRIES = 8;

	localparam int DATA_W     = 11;
	localparam int FUNC_W     = 3;
	localparam int SRC_CH_W   = 4;
	localparam int SRC_CC_W   = 7;
	localparam int CALC_W     = DATA_W + 2;
	localparam int TABLE_SIZE = CHANNELS * CONTROLLERS;
	localparam int IDX_W      = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
	localparam int FILL_W     = $clog2(BUFFER_ENTRIES + 1);

	// Reciprocal for exact division of a DATA_W-bit value by CONTROLLERS.
	localparam int CTRL_W  = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
	localparam int DIV_K   = DATA_W + CTRL_W;
	localparam int RECIP_W = DATA_W + 2;
	localparam int PROD_W  = DIV_K + DATA_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << DIV_K) + CONTROLLERS - 1) / CONTROLLERS);

	localparam logic [FUNC_W-1:0] FUNC_CH_UP   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_CH_DOWN = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_CC_UP   = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CC_DOWN = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH   = 3'd5;

	localparam logic KIND_ANSWER    = 1'b0;
	localparam logic KIND_WRITEBACK = 1'b1;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [SRC_CH_W-1:0] source_channel;
		logic [SRC_CC_W-1:0] source_controller;
		logic [DATA_W-1:0]   read_address;
		logic [DATA_W-1:0]   mem_data;
	} in_item_t;

	typedef struct packed {
		logic              kind;
		logic [DATA_W-1:0] answer;
		logic [DATA_W-1:0] wb_address;
		logic [DATA_W-1:0] wb_value;
		logic              last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DIV1,
		ST_CALC,
		ST_DIV2,
		ST_DRAIN,
		ST_COMMIT,
		ST_ANS
	} state_t;

	typedef struct packed {
		logic load_in;
		logic look;
		logic div1;
		logic calc;
		logic div2;
		logic emit_wb;
		logic drain_clear;
		logic commit;
		logic emit_ans;
	} dp_cmd_t;

	typedef struct packed {
		logic is_edit;
		logic is_flush;
		logic hit;
		logic full;
		logic drain_more;
		logic out_free;
	} dp_stat_t;

	function automatic logic [DATA_W-1:0] div_ctrl(input logic [DATA_W-1:0] x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(RECIP);
		return p[DIV_K +: DATA_W];
	endfunction

	function automatic logic [SRC_CH_W-1:0] chan_mod(input logic [SRC_CH_W-1:0] x);
		logic [SRC_CH_W-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << SRC_CH_W); i++) begin
			if (x == SRC_CH_W'(i)) begin
				r = SRC_CH_W'(i % CHANNELS);
			end
		end
		return r;
	endfunction

	function automatic logic [SRC_CC_W-1:0] ctrl_mod(input logic [SRC_CC_W-1:0] x);
		logic [SRC_CC_W-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << SRC_CC_W); i++) begin
			if (x == SRC_CC_W'(i)) begin
				r = SRC_CC_W'(i % CONTROLLERS);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rewb_datapath.sv
// Datapath: item register, entry buffer with tag match, step arithmetic and result register.
`timescale 1ns / 1ps
`default_nettype none
module rewb_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rewb_pkg::in_item_t  item,
	input  wire rewb_pkg::dp_cmd_t   cmd,
	output rewb_pkg::dp_stat_t       stat,
	input  wire logic                result_ready,
	output logic                     result_valid,
	output rewb_pkg::out_item_t      result
);
	import rewb_pkg::*;

	in_item_t in_q;

	logic [DATA_W-1:0] tag_q [BUFFER_ENTRIES];
	logic [DATA_W-1:0] val_q [BUFFER_ENTRIES];
	logic [BUFFER_ENTRIES-1:0] valid_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] drain_q;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] old_q;
	logic [DATA_W-1:0] off_q;
	logic [DATA_W-1:0] nv_q;
	logic [DATA_W-1:0] nq_q;

	logic      result_valid_q;
	out_item_t result_q;

	logic              is_edit;
	logic              is_read;
	logic              is_ch_step;
	logic [CALC_W-1:0] edit_addr;
	logic [DATA_W-1:0] look_addr;
	logic              hit;
	logic [IDX_W-1:0]  hit_idx;
	logic [DATA_W-1:0] hit_val;
	logic [CALC_W-1:0] old_w;
	logic [CALC_W-1:0] base_w;
	logic [CALC_W-1:0] nv_w;
	logic [CALC_W-1:0] ctrl_rem;
	logic [DATA_W-1:0] answer;
	logic [IDX_W-1:0]  fill_idx;
	logic [IDX_W-1:0]  drain_idx;
	logic              out_free;

	assign is_edit    = (in_q.func == FUNC_CH_UP) || (in_q.func == FUNC_CH_DOWN) ||
	                    (in_q.func == FUNC_CC_UP) || (in_q.func == FUNC_CC_DOWN);
	assign is_read    = (in_q.func == FUNC_READ);
	assign is_ch_step = (in_q.func == FUNC_CH_UP) || (in_q.func == FUNC_CH_DOWN);

	assign edit_addr = CALC_W'(chan_mod(in_q.source_channel)) * CALC_W'(CONTROLLERS) +
	                   CALC_W'(ctrl_mod(in_q.source_controller));
	assign look_addr = is_edit ? edit_addr[DATA_W-1:0] : in_q.read_address;

	// First matching valid entry, lowest index first; the value is taken from that entry.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		hit_val = '0;
		for (int i = 0; i < BUFFER_ENTRIES; i++) begin
			if (!hit && valid_q[i] && (tag_q[i] == look_addr)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
				hit_val = val_q[i];
			end
		end
	end

	assign old_w  = CALC_W'(old_q);
	assign base_w = CALC_W'(off_q) * CALC_W'(CONTROLLERS);

	always_comb begin
		case (in_q.func)
			FUNC_CH_UP: begin
				if (old_w + CALC_W'(CONTROLLERS) >= CALC_W'(TABLE_SIZE))
					nv_w = old_w - base_w;
				else
					nv_w = old_w + CALC_W'(CONTROLLERS);
			end
			FUNC_CH_DOWN: begin
				if (old_w < CALC_W'(CONTROLLERS))
					nv_w = CALC_W'(TABLE_SIZE - CONTROLLERS) + old_w;
				else
					nv_w = old_w - CALC_W'(CONTROLLERS);
			end
			FUNC_CC_UP: begin
				if (old_w + CALC_W'(1) >= base_w + CALC_W'(CONTROLLERS))
					nv_w = base_w;
				else
					nv_w = old_w + CALC_W'(1);
			end
			FUNC_CC_DOWN: begin
				if (old_w == base_w)
					nv_w = base_w + CALC_W'(CONTROLLERS - 1);
				else
					nv_w = old_w - CALC_W'(1);
			end
			default: nv_w = old_w;
		endcase
	end

	assign ctrl_rem = CALC_W'(nv_q) - CALC_W'(nq_q) * CALC_W'(CONTROLLERS);

	always_comb begin
		if (is_ch_step)
			answer = nq_q + DATA_W'(1);
		else if (is_edit)
			answer = ctrl_rem[DATA_W-1:0];
		else if (is_read)
			answer = old_q;
		else
			answer = '0;
	end

	assign fill_idx  = fill_q[IDX_W-1:0];
	assign drain_idx = drain_q[IDX_W-1:0];
	assign out_free  = !result_valid_q || result_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= item;
		if (cmd.look) begin
			hit_q     <= hit;
			hit_idx_q <= hit_idx;
			addr_q    <= look_addr;
			old_q     <= hit ? hit_val : in_q.mem_data;
		end
		if (cmd.div1)
			off_q <= div_ctrl(old_q);
		if (cmd.calc)
			nv_q <= nv_w[DATA_W-1:0];
		if (cmd.div2)
			nq_q <= div_ctrl(nv_q);
		if (cmd.commit) begin
			if (hit_q) begin
				val_q[hit_idx_q] <= nv_q;
			end else begin
				tag_q[fill_idx] <= addr_q;
				val_q[fill_idx] <= nv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			drain_q <= '0;
		end else begin
			if (cmd.load_in)
				drain_q <= '0;
			else if (cmd.emit_wb)
				drain_q <= drain_q + FILL_W'(1);
			if (cmd.drain_clear) begin
				valid_q <= '0;
				fill_q  <= '0;
			end else if (cmd.commit && !hit_q) begin
				valid_q[fill_idx] <= 1'b1;
				fill_q            <= fill_q + FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit_wb || cmd.emit_ans) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_wb) begin
			result_q.kind       <= KIND_WRITEBACK;
			result_q.answer     <= '0;
			result_q.wb_address <= tag_q[drain_idx];
			result_q.wb_value   <= val_q[drain_idx];
			result_q.last       <= 1'b0;
		end else if (cmd.emit_ans) begin
			result_q.kind       <= KIND_ANSWER;
			result_q.answer     <= answer;
			result_q.wb_address <= '0;
			result_q.wb_value   <= '0;
			result_q.last       <= 1'b1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign stat.is_edit    = is_edit;
	assign stat.is_flush   = (in_q.func == FUNC_FLUSH);
	assign stat.hit        = hit_q;
	assign stat.full       = (fill_q >= FILL_W'(BUFFER_ENTRIES));
	assign stat.drain_more = (drain_q < fill_q);
	assign stat.out_free   = out_free;

endmodule
`default_nettype wire

FILE: rtl/rewb_ctrl.sv
// Controller: sequences lookup, step arithmetic, write-back drain, commit and answer.
`timescale 1ns / 1ps
`default_nettype none
module rewb_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire rewb_pkg::dp_stat_t stat,
	output rewb_pkg::dp_cmd_t       cmd
);
	import rewb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				if (stat.is_edit)
					state_d = ST_DIV1;
				else if (stat.is_flush)
					state_d = ST_DRAIN;
				else
					state_d = ST_ANS;
			end
			ST_DIV1: begin
				cmd.div1 = 1'b1;
				state_d  = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div2 = 1'b1;
				if (!stat.hit && stat.full)
					state_d = ST_DRAIN;
				else
					state_d = ST_COMMIT;
			end
			ST_DRAIN: begin
				// Stream one entry per free output slot, then clear the buffer.
				if (stat.drain_more) begin
					cmd.emit_wb = stat.out_free;
				end else begin
					cmd.drain_clear = 1'b1;
					state_d         = stat.is_edit ? ST_COMMIT : ST_ANS;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_ANS;
			end
			ST_ANS: begin
				if (stat.out_free) begin
					cmd.emit_ans = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/routing_entry_edit_write_buffer.sv
// Top level of the routing entry edit write buffer: controller plus datapath.
// An item is taken only when the block is idle. A read or an undefined function
// is answered straight after the lookup, and a flush after the lookup and the
// write-back of every buffered entry. An edit steps through the lookup, a
// reciprocal-multiply division by the controller count, the step arithmetic, a
// second such division and the commit, and drains the buffer before the commit
// when it misses a full buffer; write-backs leave one per cycle from the
// single-entry result register while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module routing_entry_edit_write_buffer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire rewb_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output rewb_pkg::out_item_t      result
);
	import rewb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rewb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rewb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
`default_nettype wire

FILE: rtl/rewb_checker.sv
// Port-level checker for the routing entry edit write buffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rewb_port_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire rewb_pkg::out_item_t result,
	input wire logic                result_valid,
	input wire logic                result_ready
);
	import rewb_pkg::*;

	// Hold a stalled result.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// Only the answer closes an item.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.kind != result.last))
		else $error("last flag does not match result kind");

	a_answer_zero_wb: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind == KIND_ANSWER) |->
			(result.wb_address == '0) && (result.wb_value == '0))
		else $error("answer result carries write-back fields");

	// One item at a time: ready drops right after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in progress");

endmodule

bind routing_entry_edit_write_buffer rewb_port_checker u_rewb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready)
);
`default_nettype wire
